// ===== rtl/ckf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckf_pkg
// Shared constants, codes and controller/datapath interface types of the
// keyframe color fader.
// ---------------------------------------------------------------------------
package ckf_pkg;

    localparam int NUM_LISTS_DEF   = 4;
    localparam int MAX_ENTRIES_DEF = 16;

    localparam int COLOR_BITS = 10;
    localparam int HOLD_W     = 15;
    localparam int TOTAL_W    = 20;
    localparam int LC_W       = 3;
    localparam int TR_W       = 16;
    localparam int CL_W       = 3;
    localparam int KF_W       = 3 * COLOR_BITS + HOLD_W;
    localparam int DIV_N_W    = 32;
    localparam int DIV_D_W    = TOTAL_W;
    localparam int PROD_W     = COLOR_BITS + TR_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam int LIST_COUNT_RST = 4;
    localparam int TRANSITION_RST = 1000;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_ADV   = 2'd2;

    localparam logic CFG_LIST_COUNT = 1'b0;
    localparam logic CFG_TRANSITION = 1'b1;

    localparam logic [1:0] OSEL_ZERO = 2'd0;
    localparam logic [1:0] OSEL_CUR  = 2'd1;
    localparam logic [1:0] OSEL_XF   = 2'd2;

    localparam logic [1:0] DST_CUR  = 2'd0;
    localparam logic [1:0] DST_LAST = 2'd1;
    localparam logic [1:0] DST_XF   = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       exec;
        logic       fade;
        logic       wl_cur;
        logic       wl_prev;
        logic       div_mod;
        logic       take_mod;
        logic       rd_walk;
        logic       walk_step;
        logic       rd_seg;
        logic       get_seg;
        logic       rd_pred;
        logic       get_pred;
        logic       bl_clr;
        logic       bl_mul;
        logic       bl_div;
        logic       bl_take;
        logic [1:0] bl_dst;
        logic       set_status;
        logic       load_out;
        logic [1:0] out_sel;
    } ckf_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       empty;
        logic       walk_hit;
        logic       walk_last;
        logic       div_done;
        logic       k_last;
        logic       fading;
        logic       out_free;
    } ckf_stat_t;

endpackage

// ===== rtl/led_keyframe_color_fader.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_keyframe_color_fader
// Looping RGB keyframe lists with hold times, crossfaded on list rotation.
// ---------------------------------------------------------------------------
// One item at a time. Load and advance items pass through the exec, fade
// and output states. A query takes the modulo of the time over the list
// total, walks the current list for the segment and blends the three
// channels; a fading query also walks the previous list and adds three
// crossfade blends. The shared one-bit-per-cycle divider (32 steps) serves
// the modulo and every blend; the walk reads one keyframe per read/check
// state pair from the store RAM. The result register frees the sequencer,
// so the next item is taken while a result waits.
module led_keyframe_color_fader
    import ckf_pkg::*;
#(
    parameter int NUM_LISTS   = NUM_LISTS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [31:0]           now_ms,
    input  logic signed [15:0]    time_offset,
    input  logic [1:0]            list_sel,
    input  logic [3:0]            entry_index,
    input  logic                  entry_last,
    input  logic [COLOR_BITS-1:0] red_in,
    input  logic [COLOR_BITS-1:0] grn_in,
    input  logic [COLOR_BITS-1:0] blue_in,
    input  logic [HOLD_W-1:0]     hold_ms,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [TR_W-1:0]       cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COLOR_BITS-1:0] red_out,
    output logic [COLOR_BITS-1:0] green_out,
    output logic [COLOR_BITS-1:0] blue_out,
    output logic [1:0]            active_list,
    output logic                  fading,
    output logic                  status
);

    ckf_cmd_t  cmd;
    ckf_stat_t stat;
    logic      unused_last;

    // entry_last carries no information beyond entry_index
    assign unused_last = entry_last;

    ckf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ckf_datapath #(
        .NUM_LISTS   (NUM_LISTS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .now_ms      (now_ms),
        .time_offset (time_offset),
        .list_sel    (list_sel),
        .entry_index (entry_index),
        .red_in      (red_in),
        .grn_in      (grn_in),
        .blue_in     (blue_in),
        .hold_ms     (hold_ms),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .active_list (active_list),
        .fading      (fading),
        .status      (status)
    );

endmodule

// ===== rtl/ckf_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckf_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module ckf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ckf_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckf_div
// Iterative restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ckf_div #(
    parameter int NW = 32,
    parameter int DW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [NW-1:0] quot_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    assign shifted = {rem_reg, quot_reg[NW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(NW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[DW])
            begin
                rem_reg  <= diff[DW-1:0];
                quot_reg <= {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[DW-1:0];
                quot_reg <= {quot_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/ckf_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckf_datapath
// Keyframe store, list bookkeeping, segment walk, shared divider and blend
// arithmetic, result register.
// ---------------------------------------------------------------------------
module ckf_datapath
    import ckf_pkg::*;
#(
    parameter int NUM_LISTS   = NUM_LISTS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ckf_cmd_t              cmd,
    output ckf_stat_t             stat,
    input  logic [1:0]            mode,
    input  logic [31:0]           now_ms,
    input  logic signed [15:0]    time_offset,
    input  logic [1:0]            list_sel,
    input  logic [3:0]            entry_index,
    input  logic [COLOR_BITS-1:0] red_in,
    input  logic [COLOR_BITS-1:0] grn_in,
    input  logic [COLOR_BITS-1:0] blue_in,
    input  logic [HOLD_W-1:0]     hold_ms,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [TR_W-1:0]       cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COLOR_BITS-1:0] red_out,
    output logic [COLOR_BITS-1:0] green_out,
    output logic [COLOR_BITS-1:0] blue_out,
    output logic [1:0]            active_list,
    output logic                  fading,
    output logic                  status
);

    localparam int LIDX_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int EIDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LEN_W  = $clog2(MAX_ENTRIES + 1);
    localparam int DEPTH  = NUM_LISTS * MAX_ENTRIES;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PREV_RST = ((LIST_COUNT_RST > NUM_LISTS) ? NUM_LISTS : LIST_COUNT_RST) - 1;

    // latched item
    logic [1:0]            mode_reg;
    logic [31:0]           now_reg;
    logic [31:0]           t_reg;
    logic [1:0]            sel_reg;
    logic [3:0]            idx_reg;
    logic [COLOR_BITS-1:0] rin_reg;
    logic [COLOR_BITS-1:0] gin_reg;
    logic [COLOR_BITS-1:0] bin_reg;
    logic [HOLD_W-1:0]     hold_reg;

    // block state
    logic [LEN_W-1:0]   list_len_reg [NUM_LISTS];
    logic [TOTAL_W-1:0] list_tot_reg [NUM_LISTS];
    logic [CL_W-1:0]    cur_reg;
    logic [CL_W-1:0]    prev_reg;
    logic [31:0]        fade_start_reg;
    logic [LC_W-1:0]    list_count_reg;
    logic [TR_W-1:0]    tr_reg;

    // query working registers
    logic [TR_W-1:0]       e_reg;
    logic                  fading_reg;
    logic [CL_W-1:0]       wl_reg;
    logic [TOTAL_W-1:0]    rem_reg;
    logic [EIDX_W-1:0]     c_reg;
    logic [HOLD_W-1:0]     h_reg;
    logic [COLOR_BITS-1:0] pc_reg [3];
    logic [COLOR_BITS-1:0] cc_reg [3];
    logic [COLOR_BITS-1:0] cur_col_reg [3];
    logic [COLOR_BITS-1:0] last_col_reg [3];
    logic [COLOR_BITS-1:0] xf_col_reg [3];
    logic [1:0]            k_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  neg_reg;
    logic [COLOR_BITS-1:0] a_reg;
    logic [DIV_D_W-1:0]    den_reg;
    logic                  status_reg;

    // result register
    logic                  out_valid_reg;
    logic [COLOR_BITS-1:0] rout_reg;
    logic [COLOR_BITS-1:0] gout_reg;
    logic [COLOR_BITS-1:0] bout_reg;
    logic [1:0]            act_reg;
    logic                  fade_out_reg;
    logic                  stat_out_reg;

    logic [LIDX_W-1:0]     lsel;
    logic [LEN_W-1:0]      len_rd;
    logic [TOTAL_W-1:0]    tot_rd;
    logic                  ld_ok;
    logic [HOLD_W-1:0]     hold1;
    logic [TOTAL_W:0]      tot_sum;
    logic [TOTAL_W-1:0]    tot_new;
    logic [31:0]           n_eff;
    logic [31:0]           cur_inc;
    logic [31:0]           diff;
    logic [TR_W-1:0]       e_calc;
    logic                  ram_we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [KF_W-1:0]       wdata;
    logic [KF_W-1:0]       rdata;
    logic [HOLD_W-1:0]     rd_hold;
    logic [COLOR_BITS-1:0] rd_col [3];
    logic [EIDX_W-1:0]     p_idx;
    logic [EIDX_W-1:0]     r_idx;
    logic                  walk_hit;
    logic                  walk_last;
    logic                  div_start;
    logic [DIV_N_W-1:0]    div_n;
    logic [DIV_D_W-1:0]    div_d;
    logic                  div_done;
    logic [DIV_N_W-1:0]    div_q;
    logic [DIV_D_W-1:0]    div_r;
    logic                  xf;
    logic [COLOR_BITS-1:0] bl_a;
    logic [COLOR_BITS-1:0] bl_b;
    logic [COLOR_BITS-1:0] bl_mag;
    logic [TR_W-1:0]       bl_num;
    logic [DIV_D_W-1:0]    bl_den;
    logic [COLOR_BITS-1:0] bl_q;
    logic [COLOR_BITS-1:0] bl_res;
    logic                  out_take;

    assign lsel    = cmd.exec ? LIDX_W'(sel_reg) : LIDX_W'(wl_reg);
    assign len_rd  = list_len_reg[lsel];
    assign tot_rd  = list_tot_reg[lsel];
    assign ld_ok   = (mode_reg == MODE_LOAD) && (32'(sel_reg) < NUM_LISTS)
                     && (32'(idx_reg) < MAX_ENTRIES);
    assign hold1   = (hold_reg == '0) ? HOLD_W'(1) : hold_reg;
    assign tot_sum = {1'b0, tot_rd} + (TOTAL_W + 1)'(hold1);
    assign tot_new = (idx_reg == '0) ? TOTAL_W'(hold1)
                   : (tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0]);

    assign n_eff   = (list_count_reg == '0) ? 32'd1
                   : ((32'(list_count_reg) > NUM_LISTS) ? 32'(NUM_LISTS)
                                                        : 32'(list_count_reg));
    assign cur_inc = 32'(cur_reg) + 32'd1;

    assign diff   = now_reg - fade_start_reg;
    assign e_calc = diff[31] ? '0
                  : ((diff > 32'(tr_reg)) ? tr_reg : diff[TR_W-1:0]);

    assign ram_we = cmd.exec && ld_ok;
    assign waddr  = AW'(32'(LIDX_W'(sel_reg)) * MAX_ENTRIES + 32'(idx_reg));
    assign wdata  = {rin_reg, gin_reg, bin_reg, hold1};

    assign rd_hold   = rdata[HOLD_W-1:0];
    assign rd_col[0] = rdata[KF_W-1 -: COLOR_BITS];
    assign rd_col[1] = rdata[KF_W-1-COLOR_BITS -: COLOR_BITS];
    assign rd_col[2] = rdata[HOLD_W +: COLOR_BITS];

    assign p_idx  = (c_reg == '0) ? EIDX_W'(32'(len_rd) - 32'd1) : c_reg - 1'b1;
    assign r_idx  = cmd.rd_pred ? p_idx : c_reg;
    assign raddr  = AW'(32'(LIDX_W'(wl_reg)) * MAX_ENTRIES + 32'(r_idx));

    assign walk_hit  = rem_reg < TOTAL_W'(rd_hold);
    assign walk_last = (32'(c_reg) + 32'd1) >= 32'(len_rd);

    assign xf     = (cmd.bl_dst == DST_XF);
    assign bl_a   = xf ? last_col_reg[k_reg] : pc_reg[k_reg];
    assign bl_b   = xf ? cur_col_reg[k_reg] : cc_reg[k_reg];
    assign bl_mag = (bl_a >= bl_b) ? bl_a - bl_b : bl_b - bl_a;
    assign bl_num = xf ? e_reg : TR_W'(rem_reg[HOLD_W-1:0]);
    assign bl_den = xf ? DIV_D_W'(tr_reg)
                  : ((h_reg == '0) ? DIV_D_W'(1) : DIV_D_W'(h_reg));
    assign bl_q   = div_q[COLOR_BITS-1:0];
    assign bl_res = neg_reg ? a_reg + bl_q : a_reg - bl_q;

    assign div_start = cmd.div_mod || cmd.bl_div;
    assign div_n     = cmd.div_mod ? t_reg : DIV_N_W'(prod_reg);
    assign div_d     = cmd.div_mod ? tot_rd : den_reg;

    assign out_take = out_valid_reg && !out_stall;

    ckf_ram #(
        .WIDTH (KF_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ckf_div #(
        .NW (DIV_N_W),
        .DW (DIV_D_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // configuration and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_count_reg <= LC_W'(LIST_COUNT_RST);
            tr_reg         <= TR_W'(TRANSITION_RST);
            cur_reg        <= '0;
            prev_reg       <= CL_W'(PREV_RST);
            fade_start_reg <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                list_len_reg[i] <= '0;
                list_tot_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIST_COUNT: list_count_reg <= cfg_data[LC_W-1:0];
                    CFG_TRANSITION: tr_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ram_we)
            begin
                list_len_reg[LIDX_W'(sel_reg)] <= LEN_W'(32'(idx_reg) + 32'd1);
                list_tot_reg[LIDX_W'(sel_reg)] <= tot_new;
            end
            if (cmd.exec && (mode_reg == MODE_ADV))
            begin
                prev_reg       <= cur_reg;
                cur_reg        <= (cur_inc >= n_eff) ? '0 : CL_W'(cur_inc);
                fade_start_reg <= now_reg;
            end
        end
    end

    // item and query working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg   <= mode;
            now_reg    <= now_ms;
            t_reg      <= now_ms + 32'(time_offset);
            sel_reg    <= list_sel;
            idx_reg    <= entry_index;
            rin_reg    <= red_in;
            gin_reg    <= grn_in;
            bin_reg    <= blue_in;
            hold_reg   <= hold_ms;
            status_reg <= 1'b0;
        end
        if (cmd.set_status)
        begin
            status_reg <= 1'b1;
        end
        if (cmd.fade)
        begin
            e_reg      <= e_calc;
            fading_reg <= (tr_reg != '0) && (e_calc < tr_reg);
        end
        if (cmd.wl_cur)
        begin
            wl_reg <= cur_reg;
        end
        if (cmd.wl_prev)
        begin
            wl_reg <= prev_reg;
        end
        if (cmd.take_mod)
        begin
            rem_reg <= div_r;
            c_reg   <= '0;
        end
        if (cmd.walk_step && !walk_hit)
        begin
            rem_reg <= rem_reg - TOTAL_W'(rd_hold);
            c_reg   <= walk_last ? '0 : c_reg + 1'b1;
        end
        if (cmd.get_seg)
        begin
            h_reg <= rd_hold;
            for (int i = 0; i < 3; i++)
            begin
                cc_reg[i] <= rd_col[i];
            end
            if (rem_reg > TOTAL_W'(rd_hold))
            begin
                rem_reg <= TOTAL_W'(rd_hold);
            end
        end
        if (cmd.get_pred)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pc_reg[i] <= rd_col[i];
            end
        end
        if (cmd.bl_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.bl_take)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.bl_mul)
        begin
            prod_reg <= PROD_W'(bl_mag) * PROD_W'(bl_num);
            a_reg    <= bl_a;
            neg_reg  <= bl_a < bl_b;
            den_reg  <= bl_den;
        end
        if (cmd.bl_take)
        begin
            case (cmd.bl_dst)
                DST_CUR:  cur_col_reg[k_reg] <= bl_res;
                DST_LAST: last_col_reg[k_reg] <= bl_res;
                DST_XF:   xf_col_reg[k_reg] <= bl_res;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.out_sel)
                OSEL_CUR:
                begin
                    rout_reg <= cur_col_reg[0];
                    gout_reg <= cur_col_reg[1];
                    bout_reg <= cur_col_reg[2];
                end
                OSEL_XF:
                begin
                    rout_reg <= xf_col_reg[0];
                    gout_reg <= xf_col_reg[1];
                    bout_reg <= xf_col_reg[2];
                end
                default:
                begin
                    rout_reg <= '0;
                    gout_reg <= '0;
                    bout_reg <= '0;
                end
            endcase
            act_reg      <= cur_reg[1:0];
            fade_out_reg <= fading_reg;
            stat_out_reg <= status_reg;
        end
    end

    assign stat.mode      = mode_reg;
    assign stat.empty     = (32'(wl_reg) >= NUM_LISTS) || (len_rd == '0) || (tot_rd == '0);
    assign stat.walk_hit  = walk_hit;
    assign stat.walk_last = walk_last;
    assign stat.div_done  = div_done;
    assign stat.k_last    = (k_reg == 2'd2);
    assign stat.fading    = fading_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign red_out     = rout_reg;
    assign green_out   = gout_reg;
    assign blue_out    = bout_reg;
    assign active_list = act_reg;
    assign fading      = fade_out_reg;
    assign status      = stat_out_reg;

endmodule

// ===== rtl/ckf_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckf_ctrl
// Sequencer: item intake, list walks, blend passes and result hand-off.
// ---------------------------------------------------------------------------
module ckf_ctrl
    import ckf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  ckf_stat_t stat,
    output ckf_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_FADE   = 4'd2;
    localparam logic [3:0] S_LSTART = 4'd3;
    localparam logic [3:0] S_MOD    = 4'd4;
    localparam logic [3:0] S_WRD    = 4'd5;
    localparam logic [3:0] S_WCHK   = 4'd6;
    localparam logic [3:0] S_RDC    = 4'd7;
    localparam logic [3:0] S_GETC   = 4'd8;
    localparam logic [3:0] S_RDP    = 4'd9;
    localparam logic [3:0] S_GETP   = 4'd10;
    localparam logic [3:0] S_BMUL   = 4'd11;
    localparam logic [3:0] S_BDIV   = 4'd12;
    localparam logic [3:0] S_BWAIT  = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       pass_reg;
    logic       pass_next;
    logic       xf_reg;
    logic       xf_next;
    logic [1:0] osel_reg;
    logic [1:0] osel_next;
    logic [1:0] dst;

    assign dst = xf_reg ? DST_XF : (pass_reg ? DST_LAST : DST_CUR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            xf_reg    <= 1'b0;
            osel_reg  <= OSEL_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            xf_reg    <= xf_next;
            osel_reg  <= osel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        xf_next    = xf_reg;
        osel_next  = osel_reg;
        cmd        = '0;
        cmd.bl_dst = dst;
        cmd.out_sel = osel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FADE;
            end
            S_FADE:
            begin
                cmd.fade  = 1'b1;
                pass_next = 1'b0;
                xf_next   = 1'b0;
                if (stat.mode == MODE_QUERY)
                begin
                    cmd.wl_cur = 1'b1;
                    state_next = S_LSTART;
                end
                else
                begin
                    osel_next  = OSEL_ZERO;
                    state_next = S_OUT;
                end
            end
            S_LSTART:
            begin
                if (stat.empty)
                begin
                    cmd.set_status = 1'b1;
                    osel_next      = OSEL_ZERO;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.div_mod = 1'b1;
                    state_next  = S_MOD;
                end
            end
            S_MOD:
            begin
                if (stat.div_done)
                begin
                    cmd.take_mod = 1'b1;
                    state_next   = S_WRD;
                end
            end
            S_WRD:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_WCHK;
            end
            S_WCHK:
            begin
                cmd.walk_step = 1'b1;
                state_next    = (stat.walk_hit || stat.walk_last) ? S_RDC : S_WRD;
            end
            S_RDC:
            begin
                cmd.rd_seg = 1'b1;
                state_next = S_GETC;
            end
            S_GETC:
            begin
                cmd.get_seg = 1'b1;
                state_next  = S_RDP;
            end
            S_RDP:
            begin
                cmd.rd_pred = 1'b1;
                state_next  = S_GETP;
            end
            S_GETP:
            begin
                cmd.get_pred = 1'b1;
                cmd.bl_clr   = 1'b1;
                state_next   = S_BMUL;
            end
            S_BMUL:
            begin
                cmd.bl_mul = 1'b1;
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                cmd.bl_div = 1'b1;
                state_next = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.bl_take = 1'b1;
                    if (!stat.k_last)
                    begin
                        state_next = S_BMUL;
                    end
                    else if (xf_reg)
                    begin
                        osel_next  = OSEL_XF;
                        state_next = S_OUT;
                    end
                    else if (pass_reg)
                    begin
                        xf_next    = 1'b1;
                        cmd.bl_clr = 1'b1;
                        state_next = S_BMUL;
                    end
                    else if (!stat.fading)
                    begin
                        osel_next  = OSEL_CUR;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pass_next   = 1'b1;
                        cmd.wl_prev = 1'b1;
                        state_next  = S_LSTART;
                    end
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/ckf_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckf_checker
// Port-level checks of the keyframe color fader, bound to the top level.
// ---------------------------------------------------------------------------
module ckf_checker
    import ckf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [COLOR_BITS-1:0] red_out,
    input logic [COLOR_BITS-1:0] green_out,
    input logic [COLOR_BITS-1:0] blue_out,
    input logic                  status
);

    // an accepted item keeps the block busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // an empty-list result carries black
    a_status_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> red_out == '0 && green_out == '0 && blue_out == '0)
        else $error("nonzero color with empty-list status");

    // a new result only comes out of an item in progress
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(status))
        else $error("stalled result changed");

endmodule

bind led_keyframe_color_fader ckf_checker u_ckf_checker (.*);
